### hw/rtl/pss_pkg.sv
// pss_pkg: widths, constants, state encoding and fixed-point helpers
// for the parameter slew smoother. No dependencies.
package pss_pkg;

   localparam int VALUE_W   = 24;
   localparam int TIME_W    = 32;
   localparam int RATE_W    = 40;
   localparam int DIFF_W    = VALUE_W + 1;
   localparam int NV_W      = RATE_W + 2;
   localparam int MUL_A_W   = 24;
   localparam int MUL_P_W   = MUL_A_W + TIME_W;
   localparam int ACC_W     = 72;
   localparam int DIV_NUM_W = 48;
   localparam int DIV_CNT_W = 6;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;

   localparam logic [TIME_W-1:0]    MIN_SMOOTH_TIME   = 32'd1311;
   localparam logic [VALUE_W-1:0]   MIN_DIFF          = 24'd7;
   localparam logic [TIME_W-1:0]    SMOOTH_TIME_RESET = 32'd65536;
   localparam logic [VALUE_W-1:0]   HALF_Q16          = 24'd32768;
   localparam logic signed [DIFF_W-1:0] D_UNIT        = 25'sd65536;
   localparam logic signed [NV_W-1:0]   NV_UNIT       = 42'sd65536;
   localparam logic signed [NV_W-1:0]   NV_LSB        = 42'sd1;
   localparam logic signed [NV_W-1:0]   NV_SAT_MAX    = 42'sd8388607;
   localparam logic signed [NV_W-1:0]   NV_SAT_MIN    = -42'sd8388608;
   localparam logic [DIV_CNT_W-1:0] RATE_DIV_ITERS    = 6'd48;
   localparam logic [DIV_CNT_W-1:0] STEP_DIV_ITERS    = 6'd24;

   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTH_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTH_TIME = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CIRCULAR    = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_RWAIT,
      ST_STEP,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_EGO,
      ST_EWAIT,
      ST_APPLY,
      ST_DONE
   } pss_state_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_CNT_W-1:0] iters;
      logic [TIME_W-1:0]    rem_init;
      logic [DIV_NUM_W-1:0] num;
      logic [TIME_W-1:0]    divisor;
   } pss_div_cmd_type;

   function automatic logic [VALUE_W-1:0] pss_mag(input logic signed [DIFF_W-1:0] d);
      logic [DIFF_W-1:0] t;
      t = d[DIFF_W-1] ? (~d + 25'd1) : d;
      return t[VALUE_W-1:0];
   endfunction

   // shorter way around the unit circle
   function automatic logic signed [DIFF_W-1:0] pss_shorten(
      input logic signed [DIFF_W-1:0] d,
      input logic                     circ);
      logic signed [DIFF_W-1:0] r;
      r = d;
      if (circ && (pss_mag(d) > HALF_Q16)) begin
         r = d[DIFF_W-1] ? (d + D_UNIT) : (d - D_UNIT);
      end
      return r;
   endfunction

   function automatic logic [VALUE_W-1:0] pss_wrap(input logic signed [NV_W-1:0] v);
      logic signed [NV_W-1:0] t;
      logic [16:0]            r;
      logic [VALUE_W-1:0]     res;
      t = v - NV_LSB;
      r = {1'b0, t[15:0]} + 17'd1;
      if (v > NV_UNIT) begin
         res = {7'b0, r};
      end else if (v[NV_W-1]) begin
         res = {8'b0, v[15:0]};
      end else begin
         res = v[VALUE_W-1:0];
      end
      return res;
   endfunction

   function automatic logic [VALUE_W-1:0] pss_sat24(input logic signed [NV_W-1:0] v);
      logic [VALUE_W-1:0] res;
      if (v > NV_SAT_MAX) begin
         res = 24'h7FFFFF;
      end else if (v < NV_SAT_MIN) begin
         res = 24'h800000;
      end else begin
         res = v[VALUE_W-1:0];
      end
      return res;
   endfunction

endpackage

### hw/rtl/pss_if.sv
// pss_if: request and response channel interfaces (valid/ready plus payload).
// Depends on pss_pkg for field widths.
interface pss_req_if;
   import pss_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] target;
   logic [TIME_W-1:0]         time_delta;
   logic                      snap;
   modport source (output valid, target, time_delta, snap, input ready);
   modport sink (input valid, target, time_delta, snap, output ready);
endinterface

interface pss_rsp_if;
   import pss_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;
   logic                      settled;
   modport source (output valid, value, settled, input ready);
   modport sink (input valid, value, settled, output ready);
endinterface

### hw/rtl/pss_divider.sv
// pss_divider: shared restoring divider, one quotient bit per cycle.
// Used for the ramp rate and the exponential step. Depends on pss_pkg.
module pss_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  pss_pkg::pss_div_cmd_type          cmd,
   output logic                              done,
   output logic [pss_pkg::DIV_NUM_W-1:0]     quotient
);
   import pss_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [TIME_W-1:0]    rem_ff, rem_in;
   logic [TIME_W-1:0]    div_ff, div_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [TIME_W:0]      trial;
   logic [TIME_W:0]      diff;
   logic                 ge;

   always_comb begin
      trial   = {rem_ff, num_ff[DIV_NUM_W-1]};
      diff    = trial - {1'b0, div_ff};
      ge      = (trial >= {1'b0, div_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = cmd.iters;
         rem_in  = cmd.rem_init;
         div_in  = cmd.divisor;
         num_in  = cmd.num;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
         quo_in = {quo_ff[DIV_NUM_W-2:0], ge};
         num_in = {num_ff[DIV_NUM_W-2:0], 1'b0};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### hw/rtl/pss_mult.sv
// pss_mult: registered 24 x 32 unsigned multiplier, fed one operand slice
// per cycle by the sequencer. Depends on pss_pkg.
module pss_mult (
   input  logic                          clock,
   input  logic [pss_pkg::MUL_A_W-1:0]   a,
   input  logic [pss_pkg::TIME_W-1:0]    b,
   output logic [pss_pkg::MUL_P_W-1:0]   p
);
   import pss_pkg::*;

   logic [MUL_P_W-1:0] p_ff, p_in;

   always_comb begin
      p_in = {{TIME_W{1'b0}}, a} * {{MUL_A_W{1'b0}}, b};
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign p = p_ff;

endmodule

### hw/rtl/parameter_slew_smoother.sv
// parameter_slew_smoother: top level, sequencer and state of the slew smoother.
// Depends on pss_pkg, pss_if, pss_divider and pss_mult.
//
//   channel   dir  handshake             payload
//   req_ch    in   valid/ready           target, time_delta, snap
//   rsp_ch    out  valid/ready           value, settled
//   csr_*     in   csr_wr_en (no wait)   csr_index, csr_wr_data
//
// one request at a time: each passes the prep and step check states; a ramp rate
// recompute adds a pass of the serial divider (one quotient bit per cycle), a linear
// step a multiply (none at a zero rate), an exponential step a multiply and a divide.
// reset is synchronous and restores the state and control registers; datapath registers are not reset.
// a stalled response is held in the output register; the next request is
// accepted meanwhile and its result waits for the register to free.
module parameter_slew_smoother (
   input  logic                           clock,
   input  logic                           reset,
   pss_req_if.sink                        req_ch,
   pss_rsp_if.source                      rsp_ch,
   input  logic                           csr_wr_en,
   input  logic [pss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pss_pkg::CSR_DAT_W-1:0]  csr_wr_data
);
   import pss_pkg::*;

   pss_state_type             state_ff, state_in;
   logic signed [VALUE_W-1:0] cur_ff, cur_in;
   logic signed [VALUE_W-1:0] held_ff, held_in;
   logic signed [RATE_W-1:0]  rate_ff, rate_in;
   logic                      stale_ff, stale_in;
   logic                      redo_ff, redo_in;
   logic                      mode_ff, mode_in;
   logic                      circ_ff, circ_in;
   logic [TIME_W-1:0]         stime_ff, stime_in;
   logic [TIME_W-1:0]         dt_ff, dt_in;
   logic [RATE_W-1:0]         m_ff, m_in;
   logic [ACC_W-1:0]          acc_ff, acc_in;
   logic [RATE_W-1:0]         step_ff, step_in;
   logic                      neg_ff, neg_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]        rsp_value_ff, rsp_value_in;
   logic                      rsp_settled_ff, rsp_settled_in;

   pss_div_cmd_type           div_cmd;
   logic                      div_done;
   logic [DIV_NUM_W-1:0]      div_quo;
   logic [MUL_A_W-1:0]        mul_a;
   logic [MUL_P_W-1:0]        mul_p;

   logic [TIME_W-1:0]         hold;
   logic signed [DIFF_W-1:0]  d;
   logic signed [DIFF_W-1:0]  ds;
   logic [VALUE_W-1:0]        ad_raw;
   logic [VALUE_W-1:0]        ads;
   logic [RATE_W-1:0]         rate_mag;
   logic [RATE_W-1:0]         qn;
   logic [ACC_W-1:0]          sum;
   logic signed [NV_W-1:0]    cur_x;
   logic signed [NV_W-1:0]    held_x;
   logic signed [NV_W-1:0]    step_x;
   logic signed [NV_W-1:0]    nv;
   logic signed [NV_W-1:0]    nv_clamp;
   logic                      accept;
   logic                      rsp_load;

   pss_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .done     (div_done),
      .quotient (div_quo)
   );

   pss_mult u_mult (
      .clock (clock),
      .a     (mul_a),
      .b     (dt_ff),
      .p     (mul_p)
   );

   // shared arithmetic views of the held state
   always_comb begin
      hold     = mode_ff ? {3'b0, stime_ff[TIME_W-1:3]} : stime_ff;
      d        = {held_ff[VALUE_W-1], held_ff} - {cur_ff[VALUE_W-1], cur_ff};
      ds       = pss_shorten(d, circ_ff);
      ad_raw   = pss_mag(d);
      ads      = pss_mag(ds);
      rate_mag = rate_ff[RATE_W-1] ? (~rate_ff + 40'd1) : rate_ff;
      qn       = (div_quo[RATE_W-1:0] == '0) ? 40'd1 : div_quo[RATE_W-1:0];
      sum      = acc_ff + {mul_p[47:0], 24'b0};
      cur_x    = {{(NV_W-VALUE_W){cur_ff[VALUE_W-1]}}, cur_ff};
      held_x   = {{(NV_W-VALUE_W){held_ff[VALUE_W-1]}}, held_ff};
      step_x   = {2'b0, step_ff};
      nv       = neg_ff ? (cur_x - step_x) : (cur_x + step_x);
      nv_clamp = nv;
      if ((neg_ff && (nv < held_x)) || (!neg_ff && (nv > held_x))) begin
         nv_clamp = held_x;
      end
   end

   // configuration registers
   always_comb begin
      mode_in  = mode_ff;
      stime_in = stime_ff;
      circ_in  = circ_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SMOOTH_MODE: mode_in  = csr_wr_data[0];
            CSR_SMOOTH_TIME: stime_in = csr_wr_data;
            CSR_CIRCULAR:    circ_in  = csr_wr_data[0];
            default:         mode_in  = mode_ff;
         endcase
      end
   end

   // sequencer
   always_comb begin
      accept          = req_ch.valid && (state_ff == ST_IDLE);
      rsp_load        = 1'b0;
      state_in        = state_ff;
      cur_in          = cur_ff;
      held_in         = held_ff;
      rate_in         = rate_ff;
      stale_in        = stale_ff;
      redo_in         = redo_ff;
      dt_in           = dt_ff;
      m_in            = m_ff;
      acc_in          = acc_ff;
      step_in         = step_ff;
      neg_in          = neg_ff;
      mul_a           = m_ff[MUL_A_W-1:0];
      div_cmd         = '0;
      div_cmd.divisor = stime_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_SMOOTH_MODE: stale_in = stale_ff | (csr_wr_data[0] != mode_ff);
            CSR_SMOOTH_TIME: stale_in = 1'b1;
            CSR_CIRCULAR:    stale_in = 1'b1;
            default:         stale_in = stale_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               held_in  = req_ch.target;
               cur_in   = req_ch.snap ? req_ch.target : cur_ff;
               dt_in    = req_ch.time_delta;
               redo_in  = stale_ff || req_ch.snap || (req_ch.target != held_ff);
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            stale_in = 1'b0;
            state_in = ST_STEP;
            if (redo_ff) begin
               rate_in = '0;
               if ((stime_ff > MIN_SMOOTH_TIME) && (ad_raw > MIN_DIFF) && (ads != '0)) begin
                  div_cmd.start    = 1'b1;
                  div_cmd.iters    = RATE_DIV_ITERS;
                  div_cmd.rem_init = '0;
                  div_cmd.num      = {ads, 24'b0};
                  div_cmd.divisor  = stime_ff;
                  state_in         = ST_RWAIT;
               end
            end
         end
         ST_RWAIT: begin
            if (div_done) begin
               rate_in  = ds[DIFF_W-1] ? (~qn + 40'd1) : qn;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if ((dt_ff == '0) || (held_ff == cur_ff)) begin
               state_in = ST_DONE;
            end else if (dt_ff >= hold) begin
               cur_in   = held_ff;
               state_in = ST_DONE;
            end else if (mode_ff) begin
               m_in     = {16'b0, ads};
               neg_in   = ds[DIFF_W-1];
               state_in = ST_MUL0;
            end else if (rate_ff == '0) begin
               // zero rate lands on the target
               step_in  = {16'b0, ad_raw};
               neg_in   = d[DIFF_W-1];
               state_in = ST_APPLY;
            end else begin
               m_in     = rate_mag;
               neg_in   = rate_ff[RATE_W-1];
               state_in = ST_MUL0;
            end
         end
         ST_MUL0: begin
            mul_a    = m_ff[MUL_A_W-1:0];
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            mul_a    = {8'b0, m_ff[RATE_W-1:MUL_A_W]};
            acc_in   = {16'b0, mul_p};
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            if (mode_ff) begin
               acc_in   = sum;
               state_in = ST_EGO;
            end else begin
               // step saturates at all ones when the product exceeds 64 bits
               step_in  = (sum[ACC_W-1:64] != '0) ? '1 : sum[63:24];
               state_in = ST_APPLY;
            end
         end
         ST_EGO: begin
            div_cmd.start    = 1'b1;
            div_cmd.iters    = STEP_DIV_ITERS;
            div_cmd.rem_init = acc_ff[55:24];
            div_cmd.num      = {acc_ff[23:0], 24'b0};
            div_cmd.divisor  = hold;
            state_in         = ST_EWAIT;
         end
         ST_EWAIT: begin
            if (div_done) begin
               step_in  = {16'b0, div_quo[VALUE_W-1:0]};
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (circ_ff) begin
               cur_in = pss_wrap(nv);
            end else if (mode_ff) begin
               cur_in = pss_sat24(nv);
            end else begin
               cur_in = pss_sat24(nv_clamp);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in   = rsp_value_ff;
      rsp_settled_in = rsp_settled_ff;
      if (rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_value_in   = cur_ff;
         rsp_settled_in = (cur_ff == held_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= '0;
         held_ff      <= '0;
         rate_ff      <= '0;
         stale_ff     <= 1'b1;
         redo_ff      <= 1'b0;
         mode_ff      <= 1'b0;
         circ_ff      <= 1'b0;
         stime_ff     <= SMOOTH_TIME_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         held_ff      <= held_in;
         rate_ff      <= rate_in;
         stale_ff     <= stale_in;
         redo_ff      <= redo_in;
         mode_ff      <= mode_in;
         circ_ff      <= circ_in;
         stime_ff     <= stime_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dt_ff          <= dt_in;
      m_ff           <= m_in;
      acc_ff         <= acc_in;
      step_ff        <= step_in;
      neg_ff         <= neg_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_settled_ff <= rsp_settled_in;
   end

   assign req_ch.ready   = (state_ff == ST_IDLE);
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.value   = rsp_value_ff;
   assign rsp_ch.settled = rsp_settled_ff;

endmodule
